// File: rtl/ddwpi_pkg.sv
// ----------------------------------------------------------------------------
// ddwpi_pkg: shared types and constants of the wheel speed PI controller
// Command codes, register indexes, reset values and saturation limits.
// ----------------------------------------------------------------------------
package ddwpi_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_VEL    = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_IMU    = 3'd3,
    CMD_PAUSE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HALF_BASE  = 3'd0,
    REG_MAX_STEP   = 3'd1,
    REG_GAIN_LIN   = 3'd2,
    REG_GAIN_TURN  = 3'd3,
    REG_GAIN_LIN_I = 3'd4,
    REG_GAIN_TURN_I = 3'd5,
    REG_DEADZONE   = 3'd6,
    REG_IMU_THRESH = 3'd7
  } reg_idx_t;

  localparam int PAUSE_TICKS_DEF     = 100;
  localparam int IMU_FRESH_TICKS_DEF = 1;
  localparam int IMU_NEGATE_DEF      = 0;

  localparam logic [30:0] MAX_STEP_RST = 31'd1638;
  localparam logic [30:0] DEADZONE_RST = 31'd655;
  localparam logic [30:0] IMU_THR_RST  = 31'd655;

  localparam logic signed [47:0] PROD_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] PROD_MIN = -48'sh7FFF_FFFF_FFFF;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -52'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'sh7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -52'sh8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

// File: rtl/diff_drive_wheel_speed_pi_controller.sv
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_pi_controller
// Slew-limited differential-drive wheel targets with PI feedback, Q16.16.
// ----------------------------------------------------------------------------
// Channel | dir | handshake              | contents
// s_axis  | in  | s_axis_tvalid/tready   | tdata: request fields, tuser: cmd
// m_axis  | out | m_axis_tvalid/tready   | tdata: left, right; tuser: closed_loop
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Status, IMU, pause and unknown requests are handled in decode. Velocity
// commands and ticks use the single 32x32 multiplier; each Q16.16 product
// is formed as two partial products, then combine: one product for a
// velocity command and five for a tick. A tick also waits in decode while
// an earlier result is unread. Reset loads the configuration and controller
// state and clears the result valid flag; no clearing pass.
// A result waits in the output register; s_axis_tready stays low until the
// block is back in idle, while m_axis holds its result until taken.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_pi_controller #(
  parameter int PAUSE_TICKS     = ddwpi_pkg::PAUSE_TICKS_DEF,
  parameter int IMU_FRESH_TICKS = ddwpi_pkg::IMU_FRESH_TICKS_DEF,
  parameter int IMU_NEGATE      = ddwpi_pkg::IMU_NEGATE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // linear_cmd, angular_cmd, left_speed, right_speed, imu_yaw_rate, pause_on,
  // zero pad to 168 bits
  input  logic [167:0] s_axis_tdata,
  // cmd
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_target, right_target
  output logic [63:0]  m_axis_tdata,
  // closed_loop
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL_LO, S_MUL_HI, S_MUL_END,
    S_VEL_DONE, S_TICK_SLEW, S_TICK_IMU, S_TICK_PT,
    S_TICK_IL, S_TICK_IT, S_TICK_SUM, S_TICK_OUT
  } state_t;

  state_t state, ret_state;

  // configuration registers
  logic [30:0] half_wheel_base, max_step, feedback_deadzone, imu_threshold;
  logic signed [31:0] gain_linear, gain_turn, gain_linear_int, gain_turn_int;

  // controller state
  logic signed [31:0] target_linear, target_turn, current_linear;
  logic signed [31:0] measured_linear, measured_turn, last_imu_rate;
  logic [7:0]  imu_age, pause_count;
  logic        status_seen;
  logic signed [47:0] integral_linear, integral_turn;

  // latched request
  logic [2:0]         req_cmd;
  logic signed [31:0] req_lin, req_ang, req_l, req_r, req_imu;
  logic               req_pause;

  // shared multiplier: unsigned 32x32, operands as magnitudes
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] ug;
  logic [47:0] ub;
  logic        mneg;
  logic [63:0] lo_q;
  logic signed [47:0] mres;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // tick intermediates; errors are kept at full 33-bit width
  logic signed [31:0] turn_meas;
  logic signed [32:0] el, et;
  logic signed [47:0] pl, pt, il;
  logic signed [51:0] fb_r, fb_l;
  logic               imu_use;

  // combinational helpers
  logic signed [32:0] diff;
  logic [32:0]        adiff;
  logic [32:0]        aimu;
  logic signed [32:0] el_now, et_now;
  logic [32:0]        ael, aet;
  logic [51:0]        afr, afl;
  logic signed [51:0] left_w, right_w;
  logic [63:0]        m_sum;
  logic signed [31:0] cur_next;

  always_comb begin
    diff  = 33'(target_linear) - 33'(current_linear);
    adiff = diff[32] ? 33'(-diff) : 33'(diff);
    if (adiff < 33'(max_step)) cur_next = target_linear;
    else if (!diff[32] && diff != 33'sd0) cur_next = current_linear + 32'(max_step);
    else if (diff[32]) cur_next = current_linear - 32'(max_step);
    else cur_next = current_linear;
    aimu  = last_imu_rate[31] ? 33'(-34'(last_imu_rate)) : 33'(last_imu_rate);
    el_now = 33'(current_linear) - 33'(measured_linear);
    et_now = 33'(target_turn) - 33'(turn_meas);
    ael   = el_now[32] ? 33'(-el_now) : 33'(el_now);
    aet   = et_now[32] ? 33'(-et_now) : 33'(et_now);
    afr   = fb_r[51] ? 52'(-fb_r) : 52'(fb_r);
    afl   = fb_l[51] ? 52'(-fb_l) : 52'(fb_l);
    left_w  = 52'(current_linear) - 52'(target_turn);
    right_w = 52'(current_linear) + 52'(target_turn);
    if (status_seen && afr > 52'(feedback_deadzone) && afl > 52'(feedback_deadzone)) begin
      left_w  = left_w + fb_l;
      right_w = right_w + fb_r;
    end
    // (hi << 16) + (lo >> 16); hi <= 2^48, so 64 bits hold it
    m_sum = (mul_p << 16) + (lo_q >> 16);
  end

  assign s_axis_tready = !rst && (state == S_IDLE);
  assign cfg_ready     = !rst && (state == S_IDLE);

  // load multiplier operands as magnitudes
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-33'(v)) : 32'(v);
  endfunction
  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-49'(v)) : 48'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      half_wheel_base <= '0;
      max_step <= ddwpi_pkg::MAX_STEP_RST;
      gain_linear <= '0;
      gain_turn <= '0;
      gain_linear_int <= '0;
      gain_turn_int <= '0;
      feedback_deadzone <= ddwpi_pkg::DEADZONE_RST;
      imu_threshold <= ddwpi_pkg::IMU_THR_RST;
      target_linear <= '0;
      target_turn <= '0;
      current_linear <= '0;
      measured_linear <= '0;
      measured_turn <= '0;
      last_imu_rate <= '0;
      imu_age <= 8'hFF;
      status_seen <= 1'b0;
      integral_linear <= '0;
      integral_turn <= '0;
      pause_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (ddwpi_pkg::reg_idx_t'(cfg_index))
          ddwpi_pkg::REG_HALF_BASE:   half_wheel_base <= cfg_data[30:0];
          ddwpi_pkg::REG_MAX_STEP:    max_step <= cfg_data[30:0];
          ddwpi_pkg::REG_GAIN_LIN:    gain_linear <= cfg_data;
          ddwpi_pkg::REG_GAIN_TURN:   gain_turn <= cfg_data;
          ddwpi_pkg::REG_GAIN_LIN_I:  gain_linear_int <= cfg_data;
          ddwpi_pkg::REG_GAIN_TURN_I: gain_turn_int <= cfg_data;
          ddwpi_pkg::REG_DEADZONE:    feedback_deadzone <= cfg_data[30:0];
          ddwpi_pkg::REG_IMU_THRESH:  imu_threshold <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_cmd   <= s_axis_tuser;
            req_lin   <= s_axis_tdata[31:0];
            req_ang   <= s_axis_tdata[63:32];
            req_l     <= s_axis_tdata[95:64];
            req_r     <= s_axis_tdata[127:96];
            req_imu   <= s_axis_tdata[159:128];
            req_pause <= s_axis_tdata[160];
            state     <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (req_cmd)
            ddwpi_pkg::CMD_VEL: begin
              target_linear <= req_lin;
              ug <= 32'(half_wheel_base);
              ub <= 48'(mag32(req_ang));
              mneg <= req_ang[31];
              ret_state <= S_VEL_DONE;
              state <= S_MUL_LO;
            end
            ddwpi_pkg::CMD_STATUS: begin
              measured_linear <= 32'((33'(req_r) + 33'(req_l)) / 2);
              measured_turn   <= 32'((33'(req_r) - 33'(req_l)) / 2);
              status_seen <= 1'b1;
              state <= S_IDLE;
            end
            ddwpi_pkg::CMD_IMU: begin
              if (IMU_NEGATE != 0)
                last_imu_rate <= ddwpi_pkg::sat32(-52'(req_imu));
              else
                last_imu_rate <= req_imu;
              imu_age <= '0;
              state <= S_IDLE;
            end
            ddwpi_pkg::CMD_PAUSE: begin
              pause_count <= req_pause ? 8'(PAUSE_TICKS) : 8'd0;
              state <= S_IDLE;
            end
            ddwpi_pkg::CMD_TICK: begin
              // wait here until the output register is free
              if (!m_axis_tvalid || m_axis_tready) state <= S_TICK_SLEW;
              else state <= S_DECODE;
            end
            default: state <= S_IDLE;
          endcase
        end
        // shared multiplier sequence: low half, high half, combine
        S_MUL_LO: begin
          mul_a <= ug;
          mul_b <= ub[31:0];
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          lo_q  <= mul_p;
          mul_a <= ug;
          mul_b <= 32'(ub[47:32]);
          state <= S_MUL_END;
        end
        S_MUL_END: begin
          if (m_sum > 64'(ddwpi_pkg::PROD_MAX))
            mres <= mneg ? ddwpi_pkg::PROD_MIN : ddwpi_pkg::PROD_MAX;
          else
            mres <= mneg ? -48'(m_sum) : 48'(m_sum);
          state <= ret_state;
        end
        S_VEL_DONE: begin
          target_turn <= ddwpi_pkg::sat32(52'(mres));
          state <= S_IDLE;
        end
        S_TICK_SLEW: begin
          current_linear <= cur_next;
          turn_meas <= measured_turn;
          imu_use <= (32'(imu_age) < 32'(IMU_FRESH_TICKS)) && (aimu >= 33'(imu_threshold));
          ug <= 32'(half_wheel_base);
          ub <= 48'(mag32(last_imu_rate));
          mneg <= last_imu_rate[31];
          ret_state <= S_TICK_IMU;
          state <= S_MUL_LO;
        end
        S_TICK_IMU: begin
          if (imu_use) turn_meas <= ddwpi_pkg::sat32(52'(mres));
          el <= el_now;
          ug <= mag32(gain_linear);
          ub <= 48'(ael);
          mneg <= gain_linear[31] != el_now[32];
          ret_state <= S_TICK_PT;
          state <= S_MUL_LO;
        end
        S_TICK_PT: begin
          pl <= mres;
          et <= et_now;
          ug <= mag32(gain_turn);
          ub <= 48'(aet);
          mneg <= gain_turn[31] != et_now[32];
          ret_state <= S_TICK_IL;
          state <= S_MUL_LO;
        end
        S_TICK_IL: begin
          pt <= mres;
          ug <= mag32(gain_linear_int);
          ub <= mag48(integral_linear);
          mneg <= gain_linear_int[31] != integral_linear[47];
          ret_state <= S_TICK_IT;
          state <= S_MUL_LO;
        end
        S_TICK_IT: begin
          il <= mres;
          ug <= mag32(gain_turn_int);
          ub <= mag48(integral_turn);
          mneg <= gain_turn_int[31] != integral_turn[47];
          ret_state <= S_TICK_SUM;
          state <= S_MUL_LO;
        end
        S_TICK_SUM: begin
          fb_r <= 52'(pl) + 52'(pt) + 52'(il) + 52'(mres);
          fb_l <= 52'(pl) - 52'(pt) + 52'(il) - 52'(mres);
          state <= S_TICK_OUT;
        end
        S_TICK_OUT: begin
          if (status_seen) begin
            integral_linear <= ddwpi_pkg::sat48(52'(integral_linear) + 52'(el));
            integral_turn   <= ddwpi_pkg::sat48(52'(integral_turn) + 52'(et));
          end
          m_axis_tdata <= {ddwpi_pkg::sat32(right_w), ddwpi_pkg::sat32(left_w)};
          m_axis_tuser <= (pause_count == 8'd0);
          if (pause_count != 8'd0) pause_count <= pause_count - 8'd1;
          if (imu_age != 8'hFF) imu_age <= imu_age + 8'd1;
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ddwpi_checker.sv
// ----------------------------------------------------------------------------
// ddwpi_checker: port-level checks of the wheel speed controller
// Watches handshakes and result timing on the top level's ports.
// ----------------------------------------------------------------------------
module ddwpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        cfg_ready
);

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // ready drops after an accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after request");

  // a non-tick request raises no result when it leaves decode
  a_notick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != ddwpi_pkg::CMD_TICK
    |=> ##1 !$rose(m_axis_tvalid))
    else $error("result from non-tick request");

  // configuration and stream readiness go together
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == s_axis_tready)
    else $error("config ready mismatch");

endmodule

bind diff_drive_wheel_speed_pi_controller ddwpi_checker u_ddwpi_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .cfg_ready(cfg_ready)
);

// File: test/diff_drive_wheel_speed_pi_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_pi_controller_tb: self-checking bench
// Drives velocity, wheel status, IMU, pause and tick requests through the
// stream input. Every tick's wheel targets and closed-loop flag are predicted
// and checked against the stream output, in order. Both stream sides idle at
// random. Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_pi_controller_tb;

  localparam int N_RANDOM   = 650;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_PHASES   = 6;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        closed;
  } wheel_res_t;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic signed [31:0] lspd;
    logic signed [31:0] rspd;
    logic signed [31:0] yaw;
    logic               pause;
    logic               chk;     // typed-in expectation present
    logic signed [31:0] exp_l;
    logic signed [31:0] exp_r;
    logic               exp_c;
  } req_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // linear_cmd, angular_cmd, left_speed, right_speed, imu_yaw_rate, pause_on, pad
  logic [167:0] s_axis_tdata = '0;
  // cmd
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // left_target, right_target
  logic [63:0]  m_axis_tdata;
  // closed_loop
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  diff_drive_wheel_speed_pi_controller u_dut (.*);

  always #5 clk = ~clk;

  // ---------------- predictor state ----------------
  longint p_half, p_step, p_gl, p_gt, p_gli, p_gti, p_dz, p_thr;
  longint t_lin, t_turn, c_lin, m_lin, m_turn, imu_rate;
  longint integ_l, integ_t;
  int     imu_age, pause_cnt;
  bit     seen;

  wheel_res_t wheel_q[$];
  int  n_err = 0;
  bit  ok_q[$];       // typed-in expectation check per queued result
  wheel_res_t typed_q[$];
  int  rx_hold = 0;   // receiver long hold-off request

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Q16.16 product, truncated toward zero, magnitude capped at 2^47-1
  function automatic longint qprod(longint g, longint b);
    logic [127:0] m;
    bit neg;
    neg = (g < 0) != (b < 0);
    m = 128'(mag(g)) * 128'(mag(b));
    m = m >> 16;
    if (m > 128'h7FFF_FFFF_FFFF) m = 128'h7FFF_FFFF_FFFF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  task automatic model_reset();
    p_half = 0; p_step = 1638; p_gl = 0; p_gt = 0; p_gli = 0; p_gti = 0;
    p_dz = 655; p_thr = 655;
    t_lin = 0; t_turn = 0; c_lin = 0; m_lin = 0; m_turn = 0; imu_rate = 0;
    integ_l = 0; integ_t = 0; imu_age = 255; pause_cnt = 0; seen = 0;
  endtask

  task automatic model_cfg(ddwpi_pkg::reg_idx_t idx, logic [31:0] v);
    longint u, s;
    u = longint'(v[30:0]);
    s = longint'($signed(v));
    case (idx)
      ddwpi_pkg::REG_HALF_BASE:   p_half = u;
      ddwpi_pkg::REG_MAX_STEP:    p_step = u;
      ddwpi_pkg::REG_GAIN_LIN:    p_gl = s;
      ddwpi_pkg::REG_GAIN_TURN:   p_gt = s;
      ddwpi_pkg::REG_GAIN_LIN_I:  p_gli = s;
      ddwpi_pkg::REG_GAIN_TURN_I: p_gti = s;
      ddwpi_pkg::REG_DEADZONE:    p_dz = u;
      ddwpi_pkg::REG_IMU_THRESH:  p_thr = u;
      default: ;
    endcase
  endtask

  // returns 1 and fills r when the request produces wheel targets
  function automatic bit wheel_predict(req_row_t q, output wheel_res_t r);
    longint d, lft, rgt, tm, el, et, pl, pt, il, it, fr, fl;
    r = '0;
    case (q.cmd)
      ddwpi_pkg::CMD_VEL: begin
        t_lin = q.lin;
        t_turn = clip(qprod(p_half, q.ang), -64'sd2147483648, 64'sd2147483647);
        return 0;
      end
      ddwpi_pkg::CMD_STATUS: begin
        m_lin = (longint'(q.rspd) + longint'(q.lspd)) / 2;
        m_turn = (longint'(q.rspd) - longint'(q.lspd)) / 2;
        seen = 1;
        return 0;
      end
      ddwpi_pkg::CMD_IMU: begin
        imu_rate = q.yaw;
        if (ddwpi_pkg::IMU_NEGATE_DEF != 0)
          imu_rate = clip(-imu_rate, -64'sd2147483648, 64'sd2147483647);
        imu_age = 0;
        return 0;
      end
      ddwpi_pkg::CMD_PAUSE: begin
        pause_cnt = q.pause ? ddwpi_pkg::PAUSE_TICKS_DEF : 0;
        return 0;
      end
      ddwpi_pkg::CMD_TICK: ;
      default: return 0;
    endcase
    d = t_lin - c_lin;
    if (mag(d) < p_step) c_lin = t_lin;
    else if (d > 0) c_lin += p_step;
    else if (d < 0) c_lin -= p_step;
    lft = c_lin - t_turn;
    rgt = c_lin + t_turn;
    if (seen) begin
      tm = m_turn;
      if (imu_age < ddwpi_pkg::IMU_FRESH_TICKS_DEF && mag(imu_rate) >= p_thr)
        tm = clip(qprod(p_half, imu_rate), -64'sd2147483648, 64'sd2147483647);
      el = c_lin - m_lin;
      et = t_turn - tm;
      pl = qprod(p_gl, el);
      pt = qprod(p_gt, et);
      il = qprod(p_gli, integ_l);
      it = qprod(p_gti, integ_t);
      fr = pl + pt + il + it;
      fl = pl - pt + il - it;
      integ_l = clip(integ_l + el, -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF);
      integ_t = clip(integ_t + et, -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF);
      if (p_dz < mag(fr) && p_dz < mag(fl)) begin
        rgt += fr;
        lft += fl;
      end
    end
    if (imu_age < 255) imu_age++;
    if (pause_cnt > 0) begin
      r.closed = 1'b0;
      pause_cnt--;
    end else begin
      r.closed = 1'b1;
    end
    r.left  = 32'(clip(lft, -64'sd2147483648, 64'sd2147483647));
    r.right = 32'(clip(rgt, -64'sd2147483648, 64'sd2147483647));
    return 1;
  endfunction

  // ---------------- drivers ----------------
  task automatic cfg_write(ddwpi_pkg::reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    model_cfg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  int burst_left = 0;

  // sender: bursts of random length separated by random gaps
  task automatic send_req(req_row_t q);
    wheel_res_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = q.cmd;
    s_axis_tdata = {7'd0, q.pause, q.yaw, q.rspd, q.lspd, q.ang, q.lin};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (wheel_predict(q, r)) begin
      wheel_q.push_back(r);
      ok_q.push_back(q.chk);
      typed_q.push_back('{q.exp_l, q.exp_r, q.exp_c});
    end
  endtask

  task automatic idle_release();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        // long hold-off, counted here
        m_axis_tready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 9) < 3) stall = $urandom_range(1, 20);
      end
    end
  end

  always @(posedge clk) begin
    wheel_res_t e, t;
    bit k;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (wheel_q.size() == 0) begin
        $error("unexpected result left=%h right=%h", m_axis_tdata[31:0],
               m_axis_tdata[63:32]);
        n_err++;
      end else begin
        e = wheel_q.pop_front();
        k = ok_q.pop_front();
        t = typed_q.pop_front();
        if (k && t != e) begin
          $error("typed row disagrees: exp %h/%h/%b pred %h/%h/%b", t.left, t.right,
                 t.closed, e.left, e.right, e.closed);
          n_err++;
        end
        if (m_axis_tdata[31:0] !== e.left) begin
          $error("left_target exp %h got %h", e.left, m_axis_tdata[31:0]);
          n_err++;
        end
        if (m_axis_tdata[63:32] !== e.right) begin
          $error("right_target exp %h got %h", e.right, m_axis_tdata[63:32]);
          n_err++;
        end
        if (m_axis_tuser !== e.closed) begin
          $error("closed_loop exp %b got %b", e.closed, m_axis_tuser);
          n_err++;
        end
      end
    end
  end

  // watchdog: cycles with nothing accepted anywhere
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_gain();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  function automatic req_row_t mk(logic [2:0] c, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] l, logic [31:0] r, logic [31:0] y,
                                  logic p);
    req_row_t q;
    q = '{c, a, b, l, r, y, p, 1'b0, 32'sd0, 32'sd0, 1'b0};
    return q;
  endfunction

  function automatic req_row_t mkx(logic [2:0] c, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] el, logic [31:0] er, logic ec);
    req_row_t q;
    q = '{c, a, b, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, el, er, ec};
    return q;
  endfunction

  function automatic req_row_t rnd_req();
    req_row_t q;
    int k;
    q = mk(ddwpi_pkg::CMD_TICK, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
           1'($urandom_range(0, 1)));
    k = $urandom_range(0, 99);
    if (k < 45) q.cmd = ddwpi_pkg::CMD_TICK;
    else if (k < 60) q.cmd = ddwpi_pkg::CMD_VEL;
    else if (k < 75) q.cmd = ddwpi_pkg::CMD_STATUS;
    else if (k < 90) q.cmd = ddwpi_pkg::CMD_IMU;
    else if (k < 95) q.cmd = ddwpi_pkg::CMD_PAUSE;
    else q.cmd = 3'($urandom_range(5, 7));
    if (q.cmd == ddwpi_pkg::CMD_PAUSE && $urandom_range(0, 3) != 0) q.pause = 1'b0;
    return q;
  endfunction

  req_row_t dir_tab[$];

  task automatic drain();
    int w;
    w = 0;
    while (wheel_q.size() != 0 && w < 100000) begin
      @(posedge clk);
      w++;
    end
    // a trailing non-tick request may still be in flight
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int n_sent;
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: after-reset ticks, extremes, every command, odd codes
    dir_tab.push_back(mkx(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_VEL, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b0));
    dir_tab.push_back(mkx(ddwpi_pkg::CMD_TICK, 0, 0, 32'sd1638, 32'sd1638, 1'b1));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_PAUSE, 0, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mkx(ddwpi_pkg::CMD_TICK, 0, 0, 32'sd3276, 32'sd3276, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_PAUSE, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(3'd5, 32'hFFFF_FFFF, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk(3'd7, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_STATUS, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                         1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_IMU, 0, 0, 0, 0, 32'h8000_0000, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_VEL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_STATUS, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 0,
                         1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_IMU, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_VEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(ddwpi_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
    foreach (dir_tab[i]) send_req(dir_tab[i]);
    idle_release();
    drain();

    // extreme register settings, with a receiver hold-off to back up the input
    cfg_write(ddwpi_pkg::REG_HALF_BASE, 32'hFFFF_FFFF);
    cfg_write(ddwpi_pkg::REG_MAX_STEP, 32'h7FFF_FFFF);
    cfg_write(ddwpi_pkg::REG_GAIN_LIN, 32'h7FFF_FFFF);
    cfg_write(ddwpi_pkg::REG_GAIN_TURN, 32'h8000_0000);
    cfg_write(ddwpi_pkg::REG_GAIN_LIN_I, 32'h7FFF_FFFF);
    cfg_write(ddwpi_pkg::REG_GAIN_TURN_I, 32'h8000_0000);
    cfg_write(ddwpi_pkg::REG_DEADZONE, 32'h0);
    cfg_write(ddwpi_pkg::REG_IMU_THRESH, 32'h0);
    rx_hold = 300;
    n_sent = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      repeat (N_RANDOM / N_PHASES) begin
        send_req(rnd_req());
        n_sent++;
      end
      idle_release();
      drain();
      if (ph == N_PHASES - 2) begin
        cfg_write(ddwpi_pkg::REG_MAX_STEP, 32'h0);
        cfg_write(ddwpi_pkg::REG_DEADZONE, 32'h7FFF_FFFF);
        cfg_write(ddwpi_pkg::REG_IMU_THRESH, 32'h7FFF_FFFF);
        cfg_write(ddwpi_pkg::REG_HALF_BASE, 32'h0);
      end else begin
        cfg_write(ddwpi_pkg::REG_HALF_BASE, $urandom_range(0, 3) == 0 ? $urandom :
                  $urandom_range(0, 65536));
        cfg_write(ddwpi_pkg::REG_MAX_STEP, $urandom_range(0, 1) ? $urandom :
                  $urandom_range(0, 9000));
        cfg_write(ddwpi_pkg::REG_GAIN_LIN, rnd_gain());
        cfg_write(ddwpi_pkg::REG_GAIN_TURN, rnd_gain());
        cfg_write(ddwpi_pkg::REG_GAIN_LIN_I, rnd_gain());
        cfg_write(ddwpi_pkg::REG_GAIN_TURN_I, rnd_gain());
        cfg_write(ddwpi_pkg::REG_DEADZONE, $urandom_range(0, 3) == 0 ? $urandom :
                  $urandom_range(0, 2000));
        cfg_write(ddwpi_pkg::REG_IMU_THRESH, $urandom_range(0, 3) == 0 ? $urandom :
                  $urandom_range(0, 2000));
      end
    end
    drain();
    if (n_err == 0 && wheel_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
